// ===== rtl/core/osli_pkg.sv =====
`timescale 1ns / 1ps

package osli_pkg;

   // Fixed field widths of the ports
   localparam int ACTION_W  = 3;
   localparam int IN_SEQ_W  = 32;
   localparam int OUT_SEQ_W = 32;
   localparam int INDEX_W   = 10;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 11;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEF     = 1024;
   localparam int SEQ_WIDTH_DEF = 32;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_BEGIN_ALL = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_BEGIN_REL = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_NEXT      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP    = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_INC = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NULL    = 2'd3;

   // Datapath commands issued by the controller
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_PUSH,
      CMD_BEGIN_ALL,
      CMD_NEXT,
      CMD_SEARCH_INIT,
      CMD_SEARCH_READ,
      CMD_SEARCH_STEP,
      CMD_MISS,
      CMD_HIT,
      CMD_FETCH,
      CMD_OTHER,
      CMD_EMIT
   } dp_op_type;

   // Status flags reported back by the datapath
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                fetch_ok;     // begin/next will read an entry
      logic                range_empty;  // search window exhausted
      logic                cmp_eq;       // probed entry equals key
      logic                hit_ok;       // relative begin has entries to walk
      logic                out_free;     // result register can take an item
   } dp_stat_type;

endpackage

// ===== rtl/core/osli_ctrl.sv =====
`timescale 1ns / 1ps

module osli_ctrl
   import osli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_op_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_FETCH,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.action)
               ACT_PUSH: begin
                  cmd      = CMD_PUSH;
                  state_in = S_DONE;
               end
               ACT_BEGIN_ALL: begin
                  cmd      = CMD_BEGIN_ALL;
                  state_in = stat.fetch_ok ? S_FETCH : S_DONE;
               end
               ACT_NEXT: begin
                  cmd      = CMD_NEXT;
                  state_in = stat.fetch_ok ? S_FETCH : S_DONE;
               end
               ACT_BEGIN_REL, ACT_LOOKUP: begin
                  cmd      = CMD_SEARCH_INIT;
                  state_in = S_SRCH_RD;
               end
               default: begin
                  cmd      = CMD_OTHER;
                  state_in = S_DONE;
               end
            endcase
         end
         S_SRCH_RD: begin
            if (stat.range_empty) begin
               cmd      = CMD_MISS;
               state_in = S_DONE;
            end else begin
               cmd      = CMD_SEARCH_READ;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (stat.cmp_eq) begin
               cmd = CMD_HIT;
               if (stat.action == ACT_BEGIN_REL && stat.hit_ok) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cmd      = CMD_SEARCH_STEP;
               state_in = S_SRCH_RD;
            end
         end
         S_FETCH: begin
            cmd      = CMD_FETCH;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd      = CMD_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // accepted item always goes to dispatch
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DISPATCH)
      else $error("accepted item not dispatched");

   // finished result waits while the result register is busy
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !stat.out_free) |=> state_ff == S_DONE)
      else $error("result dropped while output busy");

   // a probe compare only follows a probe read
   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH_CMP |-> $past(state_ff) == S_SRCH_RD)
      else $error("compare without read");

endmodule

// ===== rtl/core/osli_dp.sv =====
`timescale 1ns / 1ps

module osli_dp
   import osli_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_op_type            cmd,
   output dp_stat_type          stat,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [IN_SEQ_W-1:0]  req_seq_value,
   input  logic                 req_after_anchor,
   input  logic                 req_reverse_order,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_SEQ_W-1:0] rsp_seq_out,
   output logic                 rsp_seq_valid,
   output logic [INDEX_W-1:0]   rsp_index_out,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_FWD,
      WALK_BACK
   } walk_type;

   // Entry store
   logic [SEQ_WIDTH-1:0] mem [DEPTH];
   logic [SEQ_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;

   // Latched item
   logic [ACTION_W-1:0]  act_ff;
   logic [SEQ_WIDTH-1:0] key_ff;
   logic                 after_ff;
   logic                 rev_ff;

   // List and walk state
   logic [CW-1:0]        count_ff;
   logic [SEQ_WIDTH-1:0] last_ff;
   logic [AW-1:0]        cursor_ff;
   logic [AW-1:0]        end_ff;
   walk_type             walk_ff;

   // Search window
   logic [CW-1:0]        lo_ff;
   logic [CW-1:0]        hi_ff;
   logic [CW-1:0]        mid;

   // Staged result and output register
   logic [SEQ_WIDTH-1:0] res_seq_ff;
   logic                 res_valid_ff;
   logic [AW-1:0]        res_index_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 rsp_valid_ff;
   logic [OUT_SEQ_W-1:0] rsp_seq_ff;
   logic                 rsp_seq_valid_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   // Derived values
   logic                 push_not_inc;
   logic                 push_full;
   logic                 push_ok;
   logic [CW-1:0]        count_m1;
   logic [CW-1:0]        cursor_c;
   logic [CW-1:0]        end_c;
   logic                 next_fwd_ok;
   logic                 next_back_ok;
   logic [CW-1:0]        next_cursor;
   logic [CW-1:0]        first_pos;
   logic [CW-1:0]        last_pos;
   logic [CW-1:0]        start_cursor;
   logic [CW-1:0]        start_end;
   logic                 hit_ok;

   assign count_m1 = count_ff - CW'(1);
   assign cursor_c = CW'(cursor_ff);
   assign end_c    = CW'(end_ff);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign push_not_inc = (count_ff != '0) && (last_ff >= key_ff);
   assign push_full    = (count_ff >= DEPTH_C);
   assign push_ok      = !push_not_inc && !push_full;

   assign next_fwd_ok  = (walk_ff == WALK_FWD) && (cursor_c < end_c)
                         && ((cursor_c + CW'(1)) < count_ff);
   assign next_back_ok = (walk_ff == WALK_BACK) && (cursor_c > end_c)
                         && ((cursor_c - CW'(1)) < count_ff);
   assign next_cursor  = next_fwd_ok ? cursor_c + CW'(1) : cursor_c - CW'(1);

   assign hit_ok = after_ff ? ((mid + CW'(1)) < count_ff) : (mid != '0);

   // Walk bounds: whole list, or one side of the anchor
   always_comb begin
      if (cmd == CMD_HIT && after_ff) begin
         first_pos = mid + CW'(1);
         last_pos  = count_m1;
      end else if (cmd == CMD_HIT) begin
         first_pos = '0;
         last_pos  = mid - CW'(1);
      end else begin
         first_pos = '0;
         last_pos  = count_m1;
      end
      start_cursor = rev_ff ? last_pos : first_pos;
      start_end    = rev_ff ? first_pos : last_pos;
   end

   always_comb begin
      unique case (cmd)
         CMD_BEGIN_ALL, CMD_HIT: rd_addr = start_cursor[AW-1:0];
         CMD_NEXT:               rd_addr = next_cursor[AW-1:0];
         CMD_SEARCH_READ:        rd_addr = mid[AW-1:0];
         default:                rd_addr = cursor_ff;
      endcase
   end

   assign mem_we = (cmd == CMD_PUSH) && push_ok;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= key_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      stat.action      = act_ff;
      stat.fetch_ok    = (act_ff == ACT_NEXT) ? (next_fwd_ok || next_back_ok)
                                              : (count_ff != '0);
      stat.range_empty = (lo_ff >= hi_ff);
      stat.cmp_eq      = (rd_data_ff == key_ff);
      stat.hit_ok      = hit_ok;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         end_ff       <= '0;
         walk_ff      <= WALK_IDLE;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd)
            CMD_LOAD: begin
               act_ff   <= req_action;
               key_ff   <= SEQ_WIDTH'(req_seq_value);
               after_ff <= req_after_anchor;
               rev_ff   <= req_reverse_order;
            end
            CMD_PUSH: begin
               res_seq_ff   <= '0;
               res_valid_ff <= 1'b0;
               res_index_ff <= '0;
               if (push_not_inc) begin
                  res_status_ff <= ST_NOT_INC;
               end else if (push_full) begin
                  res_status_ff <= ST_FULL;
               end else begin
                  res_status_ff <= ST_OK;
                  count_ff      <= count_ff + CW'(1);
                  last_ff       <= key_ff;
               end
            end
            CMD_BEGIN_ALL: begin
               res_index_ff <= '0;
               if (count_ff == '0) begin
                  walk_ff       <= WALK_IDLE;
                  res_status_ff <= ST_NULL;
                  res_seq_ff    <= '0;
                  res_valid_ff  <= 1'b0;
               end else begin
                  cursor_ff     <= start_cursor[AW-1:0];
                  end_ff        <= start_end[AW-1:0];
                  walk_ff       <= rev_ff ? WALK_BACK : WALK_FWD;
                  res_status_ff <= ST_OK;
               end
            end
            CMD_NEXT: begin
               res_index_ff <= '0;
               if (next_fwd_ok || next_back_ok) begin
                  cursor_ff     <= next_cursor[AW-1:0];
                  res_status_ff <= ST_OK;
               end else begin
                  walk_ff       <= WALK_IDLE;
                  res_status_ff <= ST_NULL;
                  res_seq_ff    <= '0;
                  res_valid_ff  <= 1'b0;
               end
            end
            CMD_SEARCH_INIT: begin
               lo_ff <= '0;
               hi_ff <= count_ff;
            end
            CMD_SEARCH_STEP: begin
               if (rd_data_ff < key_ff) begin
                  lo_ff <= mid + CW'(1);
               end else begin
                  hi_ff <= mid;
               end
            end
            CMD_MISS: begin
               if (act_ff == ACT_BEGIN_REL) begin
                  walk_ff <= WALK_IDLE;
               end
               res_status_ff <= ST_NULL;
               res_seq_ff    <= '0;
               res_valid_ff  <= 1'b0;
               res_index_ff  <= '0;
            end
            CMD_HIT: begin
               if (act_ff == ACT_LOOKUP) begin
                  res_index_ff  <= mid[AW-1:0];
                  res_status_ff <= ST_OK;
                  res_seq_ff    <= '0;
                  res_valid_ff  <= 1'b0;
               end else if (hit_ok) begin
                  res_index_ff  <= '0;
                  cursor_ff     <= start_cursor[AW-1:0];
                  end_ff        <= start_end[AW-1:0];
                  walk_ff       <= rev_ff ? WALK_BACK : WALK_FWD;
                  res_status_ff <= ST_OK;
               end else begin
                  res_index_ff  <= '0;
                  walk_ff       <= WALK_IDLE;
                  res_status_ff <= ST_NULL;
                  res_seq_ff    <= '0;
                  res_valid_ff  <= 1'b0;
               end
            end
            CMD_FETCH: begin
               res_seq_ff   <= rd_data_ff;
               res_valid_ff <= 1'b1;
            end
            CMD_OTHER: begin
               res_seq_ff    <= '0;
               res_valid_ff  <= 1'b0;
               res_index_ff  <= '0;
               res_status_ff <= ST_OK;
            end
            CMD_EMIT: begin
               rsp_valid_ff     <= 1'b1;
               rsp_seq_ff       <= OUT_SEQ_W'(res_seq_ff);
               rsp_seq_valid_ff <= res_valid_ff;
               rsp_index_ff     <= INDEX_W'(res_index_ff);
               rsp_status_ff    <= res_status_ff;
               rsp_count_ff     <= COUNT_W'(count_ff);
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seq_out     = rsp_seq_ff;
   assign rsp_seq_valid   = rsp_seq_valid_ff;
   assign rsp_index_out   = rsp_index_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      walk_ff != WALK_IDLE |-> cursor_c < count_ff)
      else $error("walk cursor outside the list");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search window inverted");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_EMIT |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

endmodule

// ===== rtl/core/ordered_sequence_list_iterator.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req_     in         req_valid/req_ready    action, seq_value, after_anchor, reverse_order
// rsp_     out        rsp_valid/rsp_ready    seq_out, seq_valid, index_out, status, entry_count
//
// One item at a time. Push and unused codes pass from dispatch straight to done;
// whole-list begin and next also read an entry when there is one. Lookup and relative
// begin run a binary search through the single read port of the store: each probe
// is a read and then a compare, at most clog2(DEPTH)+1 probes (11 at 1024). The result
// appears in the same cycle as the block becomes ready for the next item.
// Synchronous reset empties the list and stops any walk; the store itself
// is not cleared. A finished result sits in the output register; the next
// item is accepted while it waits, but its own result holds until rsp_ready.

module ordered_sequence_list_iterator
   import osli_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int SEQ_WIDTH = SEQ_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request items
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [IN_SEQ_W-1:0]  req_seq_value,
   input  logic                 req_after_anchor,
   input  logic                 req_reverse_order,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [OUT_SEQ_W-1:0] rsp_seq_out,
   output logic                 rsp_seq_valid,
   output logic [INDEX_W-1:0]   rsp_index_out,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   dp_op_type   cmd;   // controller -> datapath
   dp_stat_type stat;  // datapath -> controller

   // Sequencer: accept, dispatch on action, drive the search loop, emit
   osli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, list/walk registers, search window and output register
   osli_dp #(
      .DEPTH     (DEPTH),
      .SEQ_WIDTH (SEQ_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_seq_value     (req_seq_value),
      .req_after_anchor  (req_after_anchor),
      .req_reverse_order (req_reverse_order),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_seq_out       (rsp_seq_out),
      .rsp_seq_valid     (rsp_seq_valid),
      .rsp_index_out     (rsp_index_out),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

// ===== dv/osli_checker.sv =====
`timescale 1ns / 1ps

module osli_checker
   import osli_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [IN_SEQ_W-1:0]  req_seq_value,
   input  logic                 req_after_anchor,
   input  logic                 req_reverse_order,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [OUT_SEQ_W-1:0] rsp_seq_out,
   input  logic                 rsp_seq_valid,
   input  logic [INDEX_W-1:0]   rsp_index_out,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [COUNT_W-1:0]   rsp_entry_count,
   output int                   fail_count,
   output int                   outstanding
);

   typedef enum logic [1:0] {WALK_IDLE, WALK_UP, WALK_DOWN} walk_dir_type;

   typedef struct packed {
      logic [OUT_SEQ_W-1:0] seq;
      logic                 valid;
      logic [INDEX_W-1:0]   index;
      logic [STATUS_W-1:0]  status;
      logic [COUNT_W-1:0]   count;
   } list_result_type;

   // shadow of the list and its walk
   logic [IN_SEQ_W-1:0] list_mem [DEPTH];
   int unsigned         list_len;
   int unsigned         walk_pos;
   int unsigned         walk_stop;
   walk_dir_type        walk_dir;

   list_result_type results_due [$];
   int              mismatches  = 0;
   int              due_now     = 0;
   int              results_seen = 0;

   assign fail_count  = mismatches;
   assign outstanding = due_now;

   task automatic note_mismatch(input string msg);
      $display("%0t ns: result %0d mismatch, %s", $time, results_seen, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         note_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // binary search of the sorted list; entries at or above list_len never read
   function automatic bit find_entry(input logic [IN_SEQ_W-1:0] key,
                                     output int unsigned at);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = list_len;
      at = 0;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (list_mem[mid] == key) begin
            at = mid;
            return 1'b1;
         end
         if (list_mem[mid] < key)
            lo = mid + 1;
         else
            hi = mid;
      end
      return 1'b0;
   endfunction

   task automatic start_walk(input int unsigned first, input int unsigned last,
                             input logic backward);
      if (backward) begin
         walk_pos  = last;
         walk_stop = first;
         walk_dir  = WALK_DOWN;
      end else begin
         walk_pos  = first;
         walk_stop = last;
         walk_dir  = WALK_UP;
      end
   endtask

   task automatic apply_request(input logic [ACTION_W-1:0] act,
                                input logic [IN_SEQ_W-1:0] key,
                                input logic after, input logic rev);
      list_result_type r;
      int unsigned     hit_at;
      bit              found;
      r = '0;
      r.status = ST_OK;
      case (act)
         ACT_PUSH: begin
            if (list_len > 0 && list_mem[list_len-1] >= key)
               r.status = ST_NOT_INC;
            else if (list_len >= DEPTH)
               r.status = ST_FULL;
            else begin
               list_mem[list_len] = key;
               list_len++;
            end
         end
         ACT_BEGIN_ALL: begin
            if (list_len == 0) begin
               walk_dir = WALK_IDLE;
               r.status = ST_NULL;
            end else begin
               start_walk(0, list_len - 1, rev);
               r.seq   = list_mem[walk_pos];
               r.valid = 1'b1;
            end
         end
         ACT_BEGIN_REL: begin
            found = find_entry(key, hit_at);
            if (!found || (!after && hit_at == 0) ||
                (after && hit_at + 1 >= list_len)) begin
               walk_dir = WALK_IDLE;
               r.status = ST_NULL;
            end else begin
               if (after)
                  start_walk(hit_at + 1, list_len - 1, rev);
               else
                  start_walk(0, hit_at - 1, rev);
               r.seq   = list_mem[walk_pos];
               r.valid = 1'b1;
            end
         end
         ACT_NEXT: begin
            if (walk_dir == WALK_UP && walk_pos < walk_stop &&
                walk_pos + 1 < list_len) begin
               walk_pos++;
               r.seq   = list_mem[walk_pos];
               r.valid = 1'b1;
            end else if (walk_dir == WALK_DOWN && walk_pos > walk_stop &&
                         walk_pos - 1 < list_len) begin
               walk_pos--;
               r.seq   = list_mem[walk_pos];
               r.valid = 1'b1;
            end else begin
               walk_dir = WALK_IDLE;
               r.status = ST_NULL;
            end
         end
         ACT_LOOKUP: begin
            if (find_entry(key, hit_at))
               r.index = hit_at[INDEX_W-1:0];
            else
               r.status = ST_NULL;
         end
         default: ;
      endcase
      r.count = list_len[COUNT_W-1:0];
      results_due.insert(results_due.size(), r);
   endtask

   task automatic check_result();
      list_result_type want;
      results_seen++;
      if (results_due.size() == 0) begin
         note_mismatch($sformatf("result with none expected, status %0d", rsp_status));
      end else begin
         want = results_due.pop_front();
         check_field("seq_out", rsp_seq_out, want.seq);
         check_field("seq_valid", rsp_seq_valid, want.valid);
         check_field("index_out", rsp_index_out, want.index);
         check_field("status", rsp_status, want.status);
         check_field("entry_count", rsp_entry_count, want.count);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         list_len  = 0;
         walk_pos  = 0;
         walk_stop = 0;
         walk_dir  = WALK_IDLE;
         results_due.delete();
      end else begin
         // results first: one taken at this edge is never for an item taken now
         if (rsp_valid && rsp_ready)
            check_result();
         if (req_valid && req_ready)
            apply_request(req_action, req_seq_value, req_after_anchor, req_reverse_order);
      end
      due_now = results_due.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import osli_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEF;
   // highest action code; everything above lookup is unused
   localparam logic [ACTION_W-1:0] ACT_TOP_CODE = '1;

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action        = ACT_PUSH;
   logic [IN_SEQ_W-1:0]  req_seq_value     = '0;
   logic                 req_after_anchor  = 1'b0;
   logic                 req_reverse_order = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic [OUT_SEQ_W-1:0] rsp_seq_out;
   logic                 rsp_seq_valid;
   logic [INDEX_W-1:0]   rsp_index_out;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_entry_count;

   int fail_count;
   int outstanding;

   // idling odds, per cent, for each side; dropped to zero for one stretch
   int req_idle_pct = 31;
   int rsp_idle_pct = 31;

   // one long result hold-off, requested by the stimulus, counted by the receiver
   bit hold_request = 1'b0;
   bit hold_used    = 1'b0;
   int hold_left    = 0;

   int items_sent = 0;

   // values the list should hold, kept only to pick sensible keys and anchors
   logic [IN_SEQ_W-1:0] stored [$];

   ordered_sequence_list_iterator #(
      .DEPTH     (LIST_DEPTH),
      .SEQ_WIDTH (SEQ_WIDTH_DEF)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_seq_value     (req_seq_value),
      .req_after_anchor  (req_after_anchor),
      .req_reverse_order (req_reverse_order),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_seq_out       (rsp_seq_out),
      .rsp_seq_valid     (rsp_seq_valid),
      .rsp_index_out     (rsp_index_out),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

   osli_checker #(
      .DEPTH (LIST_DEPTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_seq_value     (req_seq_value),
      .req_after_anchor  (req_after_anchor),
      .req_reverse_order (req_reverse_order),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_seq_out       (rsp_seq_out),
      .rsp_seq_valid     (rsp_seq_valid),
      .rsp_index_out     (rsp_index_out),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always #4 clock = ~clock;

   // Hard stop. Slowest correct run is well under 1 ms (about 550 items, binary-search
   // lookups, gaps on both sides and one long hold).
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Result side. Ready changes at the falling edge only; one assignment per
   // edge. When asked, it holds off for a long stretch so the block backs up.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // Offer one item. Entered and left at a falling edge; valid stays up from
   // one item to the next when no gap is drawn, so it is never dropped and
   // raised in the same step.
   task automatic send_req(input logic [ACTION_W-1:0] act, input logic [IN_SEQ_W-1:0] val,
                           input logic after, input logic rev);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_seq_value     <= val;
      req_after_anchor  <= after;
      req_reverse_order <= rev;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      // keep the key list in step with what a push should have done
      if (act == ACT_PUSH && stored.size() < LIST_DEPTH &&
          (stored.size() == 0 || val > stored[$]))
         stored.insert(stored.size(), val);
      @(negedge clock);
   endtask

   function automatic logic [IN_SEQ_W-1:0] pick_stored();
      if (stored.size() == 0)
         return IN_SEQ_W'($urandom);
      return stored[$urandom_range(0, stored.size() - 1)];
   endfunction

   // a few steps of the current walk, sometimes past its end
   task automatic walk_on();
      repeat ($urandom_range(0, 6))
         send_req(ACT_NEXT, IN_SEQ_W'($urandom), coin(), coin());
   endtask

   // Mostly well-formed traffic: growing pushes, begins followed by walks,
   // keys that exist; a share of refused pushes, unknown keys and unused codes.
   task automatic random_item();
      int                  pick;
      logic [IN_SEQ_W-1:0] val;
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         if (stored.size() == 0)
            val = IN_SEQ_W'($urandom_range(0, 1000));
         else if ($urandom_range(0, 9) < 8)
            val = stored[$] + IN_SEQ_W'($urandom_range(1, 1 << 22));
         else if ($urandom_range(0, 1))
            val = stored[$];
         else
            val = IN_SEQ_W'($urandom_range(0, stored[$]));
         send_req(ACT_PUSH, val, coin(), coin());
      end else if (pick < 40) begin
         send_req(ACT_BEGIN_ALL, IN_SEQ_W'($urandom), coin(), coin());
         walk_on();
      end else if (pick < 58) begin
         val = ($urandom_range(0, 99) < 85) ? pick_stored() : IN_SEQ_W'($urandom);
         send_req(ACT_BEGIN_REL, val, coin(), coin());
         walk_on();
      end else if (pick < 78) begin
         send_req(ACT_NEXT, IN_SEQ_W'($urandom), coin(), coin());
      end else if (pick < 95) begin
         val = ($urandom_range(0, 99) < 70) ? pick_stored() : IN_SEQ_W'($urandom);
         send_req(ACT_LOOKUP, val, coin(), coin());
      end else begin
         send_req(ACTION_W'($urandom_range(int'(ACT_LOOKUP) + 1, int'(ACT_TOP_CODE))),
                  IN_SEQ_W'($urandom), coin(), coin());
      end
   endtask

   initial begin
      int random_end;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: empty list, then a small list of four entries
      send_req(ACT_NEXT, '0, 1'b0, 1'b0);            // next before any begin
      send_req(ACT_BEGIN_ALL, '0, 1'b0, 1'b0);       // begin on empty list
      send_req(ACT_BEGIN_REL, '0, 1'b1, 1'b1);       // anchor on empty list
      send_req(ACT_LOOKUP, '1, 1'b1, 1'b1);          // lookup on empty list
      send_req(ACT_PUSH, '0, 1'b0, 1'b0);            // lowest value
      send_req(ACT_PUSH, '0, 1'b0, 1'b0);            // equal: not increasing
      send_req(ACT_PUSH, 32'd100, 1'b0, 1'b0);
      send_req(ACT_PUSH, 32'd200, 1'b0, 1'b0);
      send_req(ACT_PUSH, 32'd300, 1'b0, 1'b0);
      send_req(ACT_BEGIN_ALL, '0, 1'b0, 1'b0);       // forward walk to the end
      repeat (4) send_req(ACT_NEXT, '0, 1'b0, 1'b0); // runs out, then idle
      send_req(ACT_BEGIN_ALL, '1, 1'b1, 1'b1);       // backward
      send_req(ACT_NEXT, '1, 1'b1, 1'b1);
      send_req(ACT_BEGIN_REL, 32'd200, 1'b0, 1'b0);  // entries before anchor
      send_req(ACT_NEXT, '0, 1'b0, 1'b0);
      send_req(ACT_BEGIN_REL, 32'd200, 1'b1, 1'b1);  // after anchor, reversed
      send_req(ACT_PUSH, 32'd400, 1'b0, 1'b0);       // push mid-walk, end held
      send_req(ACT_NEXT, '0, 1'b0, 1'b0);
      send_req(ACT_BEGIN_REL, '0, 1'b0, 1'b1);       // nothing before first
      send_req(ACT_BEGIN_REL, 32'd400, 1'b1, 1'b0);  // nothing after last
      send_req(ACT_BEGIN_REL, 32'd150, 1'b1, 1'b0);  // anchor absent
      send_req(ACT_LOOKUP, 32'd300, 1'b0, 1'b0);
      send_req(ACT_LOOKUP, 32'd150, 1'b0, 1'b0);
      for (int c = int'(ACT_LOOKUP) + 1; c <= int'(ACT_TOP_CODE); c++)
         send_req(ACTION_W'(c), '1, 1'b1, 1'b1);

      // --- random traffic; the long result hold-off lands early in it
      hold_request = 1'b1;
      random_end = items_sent + 250;
      while (items_sent < random_end)
         random_item();

      // --- a stretch with no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_end = items_sent + 120;
      while (items_sent < random_end)
         random_item();
      req_idle_pct = 31;
      rsp_idle_pct = 31;

      // --- walks around the ends of the grown list
      send_req(ACT_LOOKUP, stored[$], 1'b0, 1'b0);     // last position
      send_req(ACT_BEGIN_REL, stored[$], 1'b0, 1'b1);  // down from one below last
      repeat (3) send_req(ACT_NEXT, '0, 1'b0, 1'b0);
      send_req(ACT_BEGIN_REL, stored[0], 1'b1, 1'b0);
      send_req(ACT_NEXT, '0, 1'b0, 1'b0);
      send_req(ACT_BEGIN_ALL, '0, 1'b0, 1'b1);
      send_req(ACT_NEXT, '0, 1'b0, 1'b0);
      random_end = items_sent + 140;
      while (items_sent < random_end)
         random_item();

      req_valid <= 1'b0;

      // drain, then give the block time to show any stray result
      while (outstanding != 0)
         @(negedge clock);
      repeat (60) @(negedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== ordered_sequence_list_iterator.f =====
rtl/core/osli_pkg.sv
rtl/core/osli_ctrl.sv
rtl/core/osli_dp.sv
rtl/core/ordered_sequence_list_iterator.sv
dv/osli_checker.sv
dv/testbench.sv
